### hdl/las_pkg.sv
// ----------------------------------------------------------------------------
// las_pkg: shared constants for the diode animation sequencer
// Holds command, pattern, end-action and register codes, fixed-point
// constants and parameter defaults used by the sequencer and its divider.
// ----------------------------------------------------------------------------
package las_pkg;

  // Parameter defaults
  localparam int DiodesDef      = 8;
  localparam int LevelsDef      = 128;
  localparam int MinDurationDef = 100;
  localparam int MaxDurationDef = 60000;

  // Field widths
  localparam int ProgW   = 17;  // Q1.16 progress
  localparam int DtW     = 16;  // elapsed ms, also duration width
  localparam int QuoW    = 32;  // quotient of (dt << 16) / duration
  localparam int PhaseW  = 32;  // Q32 golden-ratio phase
  localparam int CntW    = 5;   // holds 0 .. ResultCap
  localparam int IdxOutW = 3;
  localparam int LvlOutW = 7;

  localparam int DivSteps  = QuoW;
  localparam int ResultCap = 16;

  localparam logic [ProgW-1:0]  OneQ16  = 17'h10000;
  localparam logic [ProgW-1:0]  HalfQ16 = 17'h08000;
  localparam logic [PhaseW-1:0] PhiQ32  = 32'h9E37_79B9;

  localparam int ToggleLow  = 4;
  localparam int ToggleHigh = 5;

  // Command codes
  localparam logic [1:0] ModeTick  = 2'd0;
  localparam logic [1:0] ModeStart = 2'd1;
  localparam logic [1:0] ModeStop  = 2'd2;

  // Pattern codes
  localparam logic [1:0] SelDecay  = 2'd0;
  localparam logic [1:0] SelSweep  = 2'd1;
  localparam logic [1:0] SelToggle = 2'd2;
  localparam logic [1:0] SelBad    = 2'd3;

  // End-action codes
  localparam logic [1:0] EndLoop = 2'd0;
  localparam logic [1:0] EndHold = 2'd1;
  localparam logic [1:0] EndOff  = 2'd2;
  localparam logic [1:0] EndBad  = 2'd3;

  // Register indexes
  localparam logic [1:0] CfgSelect    = 2'd0;
  localparam logic [1:0] CfgDuration  = 2'd1;
  localparam logic [1:0] CfgEndAction = 2'd2;

endpackage

### hdl/las_div.sv
// ----------------------------------------------------------------------------
// las_div: iterative restoring divider
// Divides (dt << 16) by a 16-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module las_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [las_pkg::DtW-1:0]      dt_i,
  input  logic [las_pkg::DtW-1:0]      divisor_i,
  output logic                         done_o,
  output logic [las_pkg::QuoW-1:0]     quotient_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [las_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [las_pkg::DtW-1:0]      rem_q, rem_d;
  logic [las_pkg::QuoW-1:0]     quo_q, quo_d;
  logic [las_pkg::DtW:0]        trial;
  logic                         fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[las_pkg::QuoW-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = {dt_i, {(las_pkg::QuoW - las_pkg::DtW){1'b0}}};
    end else if (busy_q) begin
      rem_d = fits ? las_pkg::DtW'(trial - {1'b0, divisor_i})
                   : trial[las_pkg::DtW-1:0];
      quo_d = {quo_q[las_pkg::QuoW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == las_pkg::CntW'(las_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### hdl/led_array_animation_sequencer.sv
// ----------------------------------------------------------------------------
// led_array_animation_sequencer: brightness frames for a row of diodes
// Start, stop and tick commands drive a Q1.16 progress value; each tick while
// playing emits a frame of the selected pattern, one word per diode.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one command word: mode_i
//   and dt_ms_i. Output channel (out_valid_o / out_stall_i) gives one word
//   per diode: diode_index_o, brightness_o, frame_last_o. frame_last_o marks
//   the final word caused by a command. A command that causes no words
//   (start, tick while idle, unused mode) is done in its accept cycle.
//   Configuration writes (cfg_valid_i / cfg_ready_o, always ready) set the
//   pattern, duration and end action; write them only while idle.
//   Sequence: a tick starts the divider, one quotient bit a cycle; the
//   sequencer then waits for the divide to finish (StDiv), advances
//   progress (StAdv) and loads the output register (StFrame). Words then
//   follow one per cycle while the output is not stalled, up to 16 per
//   command (a frame, or a frame plus an end frame). A stop goes straight
//   to StFrame and loads its first word from there. A new command is
//   taken only once the last word of the previous one is loaded.
//   Stall: a stalled output word holds; the sequencer pauses behind it.
//   Reset: progress goes to 1.0, playback stops, registers take defaults.
// ----------------------------------------------------------------------------
module led_array_animation_sequencer #(
  parameter int DIODES          = las_pkg::DiodesDef,
  parameter int LEVELS          = las_pkg::LevelsDef,
  parameter int MIN_DURATION_MS = las_pkg::MinDurationDef,
  parameter int MAX_DURATION_MS = las_pkg::MaxDurationDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      mode_i,
  input  logic [las_pkg::DtW-1:0]         dt_ms_i,
  // frame channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [las_pkg::IdxOutW-1:0]     diode_index_o,
  output logic [las_pkg::LvlOutW-1:0]     brightness_o,
  output logic                            frame_last_o,
  // configuration channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_index_i,
  input  logic [las_pkg::DtW-1:0]         cfg_data_i
);

  localparam int IdxW = $clog2(DIODES);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StDiv   = 2'd1;
  localparam logic [1:0] StAdv   = 2'd2;
  localparam logic [1:0] StFrame = 2'd3;

  localparam logic [las_pkg::LvlOutW-1:0] TopLvl = las_pkg::LvlOutW'(LEVELS - 1);
  localparam logic [IdxW-1:0]             LastIdx = IdxW'(DIODES - 1);

  // Configuration registers
  logic [1:0]                  sel_q;
  logic [las_pkg::DtW-1:0]     dur_q;
  logic [1:0]                  end_q;

  // Animation state
  logic [1:0]                  state_q, state_d;
  logic [las_pkg::ProgW-1:0]   progress_q, progress_d;
  logic                        playing_q, playing_d;

  // Frame walker
  logic [las_pkg::ProgW-1:0]   frame_p_q, frame_p_d;
  logic [las_pkg::PhaseW-1:0]  phase_q, phase_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [las_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic                        off_q, off_d;
  logic                        more_q, more_d;
  logic                        more_off_q, more_off_d;

  // Output register
  logic                        out_valid_q, out_valid_d;
  logic [las_pkg::IdxOutW-1:0] out_idx_q, out_idx_d;
  logic [las_pkg::LvlOutW-1:0] out_lvl_q, out_lvl_d;
  logic                        out_last_q, out_last_d;

  // Divider hookup
  logic                        div_start;
  logic                        div_done;
  logic [las_pkg::QuoW-1:0]    div_quo;
  logic [las_pkg::DtW-1:0]     dur_eff;

  logic                        in_acc;
  logic                        out_free;
  logic                        load;
  logic                        word_last;

  logic [las_pkg::QuoW:0]      sum;
  logic                        finished;
  logic [las_pkg::ProgW-1:0]   adv_p;

  // Pattern datapath
  logic [las_pkg::PhaseW+1:0]  decay_t;
  logic [las_pkg::PhaseW:0]    decay_diff;
  logic [las_pkg::PhaseW+8:0]  decay_prod;
  logic [8:0]                  decay_v;
  logic [8:0]                  decay_lvl;
  logic [las_pkg::ProgW+5:0]   sweep_prod;
  logic [6:0]                  sweep_pos;
  logic [las_pkg::LvlOutW-1:0] pat_lvl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= las_pkg::SelDecay;
      dur_q <= las_pkg::DtW'(1000);
      end_q <= las_pkg::EndLoop;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        las_pkg::CfgSelect:    sel_q <= cfg_data_i[1:0];
        las_pkg::CfgDuration:  dur_q <= cfg_data_i;
        las_pkg::CfgEndAction: end_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Clamp duration to its bounds, low bound first
  always_comb begin
    priority if (dur_q < las_pkg::DtW'(MIN_DURATION_MS)) begin
      dur_eff = las_pkg::DtW'(MIN_DURATION_MS);
    end else if (dur_q > las_pkg::DtW'(MAX_DURATION_MS)) begin
      dur_eff = las_pkg::DtW'(MAX_DURATION_MS);
    end else begin
      dur_eff = dur_q;
    end
  end

  las_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dt_i       (dt_ms_i),
    .divisor_i  (dur_eff),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Golden decay: t = 3 * phase; level = floor((1 - t) * LEVELS) - 1, floored at 0
  assign decay_t    = {2'b00, phase_q} + {1'b0, phase_q, 1'b0};
  assign decay_diff = {1'b1, {las_pkg::PhaseW{1'b0}}} - {1'b0, decay_t[las_pkg::PhaseW-1:0]};
  assign decay_prod = (las_pkg::PhaseW+9)'(decay_diff) * (las_pkg::PhaseW+9)'(LEVELS);
  assign decay_v    = decay_prod[las_pkg::PhaseW+8:las_pkg::PhaseW];
  assign decay_lvl  = (decay_t[las_pkg::PhaseW+1:las_pkg::PhaseW] != 2'b00 || decay_v == 9'd0)
                      ? 9'd0 : decay_v - 9'd1;

  // Sweep: lit position is floor(p * DIODES), past the row at p = 1.0
  assign sweep_prod = (las_pkg::ProgW+6)'(frame_p_q) * (las_pkg::ProgW+6)'(DIODES);
  assign sweep_pos  = sweep_prod[las_pkg::ProgW+5:16];

  always_comb begin
    unique case (sel_q)
      las_pkg::SelDecay:  pat_lvl = decay_lvl[las_pkg::LvlOutW-1:0];
      las_pkg::SelSweep:  pat_lvl = (sweep_pos == 7'(idx_q)) ? TopLvl : '0;
      las_pkg::SelToggle: begin
        if (idx_q == IdxW'(las_pkg::ToggleLow) && frame_p_q < las_pkg::HalfQ16) begin
          pat_lvl = TopLvl;
        end else if (idx_q == IdxW'(las_pkg::ToggleHigh) && frame_p_q >= las_pkg::HalfQ16) begin
          pat_lvl = TopLvl;
        end else begin
          pat_lvl = '0;
        end
      end
      default:            pat_lvl = '0;
    endcase
  end

  // Advance progress by the quotient, clamp to 1.0
  assign sum      = {{las_pkg::QuoW-las_pkg::ProgW+1{1'b0}}, progress_q} + {1'b0, div_quo};
  assign finished = sum >= (las_pkg::QuoW+1)'(las_pkg::OneQ16);
  assign adv_p    = finished ? las_pkg::OneQ16 : sum[las_pkg::ProgW-1:0];

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign load      = (state_q == StFrame) && out_free;
  // The last word: hit the cap, or end of a frame with nothing to follow
  assign word_last = (cnt_q == las_pkg::CntW'(las_pkg::ResultCap - 1)) ||
                     (idx_q == LastIdx && !more_q);

  always_comb begin
    state_d    = state_q;
    progress_d = progress_q;
    playing_d  = playing_q;
    frame_p_d  = frame_p_q;
    phase_d    = phase_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    off_d      = off_q;
    more_d     = more_q;
    more_off_d = more_off_q;
    div_start  = 1'b0;
    out_idx_d  = out_idx_q;
    out_lvl_d  = out_lvl_q;
    out_last_d = out_last_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          idx_d  = '0;
          cnt_d  = '0;
          more_d = 1'b0;
          unique case (mode_i)
            las_pkg::ModeStart: begin
              if (sel_q != las_pkg::SelBad && end_q != las_pkg::EndBad) begin
                progress_d = '0;
                playing_d  = 1'b1;
              end
            end
            las_pkg::ModeStop: begin
              progress_d = las_pkg::OneQ16;
              playing_d  = 1'b0;
              frame_p_d  = las_pkg::OneQ16;
              phase_d    = '0;
              off_d      = (end_q == las_pkg::EndOff);
              if (end_q == las_pkg::EndHold || end_q == las_pkg::EndOff) begin
                state_d = StFrame;
              end
            end
            las_pkg::ModeTick: begin
              if (playing_q) begin
                div_start = 1'b1;
                state_d   = StDiv;
              end
            end
            default: ;
          endcase
        end
      end
      StDiv: begin
        if (div_done) begin
          state_d = StAdv;
        end
      end
      StAdv: begin
        frame_p_d = adv_p;
        phase_d   = {adv_p[15:0], 16'h0000};
        off_d     = 1'b0;
        state_d   = StFrame;
        if (!finished) begin
          progress_d = adv_p;
        end else if (end_q == las_pkg::EndLoop) begin
          progress_d = '0;
        end else begin
          // Stop at the end; hold or blank with a second frame
          progress_d = las_pkg::OneQ16;
          playing_d  = 1'b0;
          more_d     = (end_q == las_pkg::EndHold || end_q == las_pkg::EndOff);
          more_off_d = (end_q == las_pkg::EndOff);
        end
      end
      StFrame: begin
        if (load) begin
          out_valid_d = 1'b1;
          out_idx_d   = idx_q[las_pkg::IdxOutW-1:0];
          out_lvl_d   = off_q ? '0 : pat_lvl;
          out_last_d  = word_last;
          cnt_d       = cnt_q + 1'b1;
          idx_d       = idx_q + 1'b1;
          phase_d     = phase_q + las_pkg::PhiQ32;
          if (word_last) begin
            state_d = StIdle;
          end else if (idx_q == LastIdx) begin
            // Start the end frame at progress 1.0
            idx_d     = '0;
            more_d    = 1'b0;
            off_d     = more_off_q;
            frame_p_d = las_pkg::OneQ16;
            phase_d   = '0;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      progress_q  <= las_pkg::OneQ16;
      playing_q   <= 1'b0;
      idx_q       <= '0;
      cnt_q       <= '0;
      more_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      progress_q  <= progress_d;
      playing_q   <= playing_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      more_q      <= more_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_p_q  <= frame_p_d;
    phase_q    <= phase_d;
    off_q      <= off_d;
    more_off_q <= more_off_d;
    out_idx_q  <= out_idx_d;
    out_lvl_q  <= out_lvl_d;
    out_last_q <= out_last_d;
  end

  assign in_stall_o    = (state_q != StIdle);
  assign out_valid_o   = out_valid_q;
  assign diode_index_o = out_idx_q;
  assign brightness_o  = out_lvl_q;
  assign frame_last_o  = out_last_q;

`ifndef SYNTH
  a_play_below_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    playing_q |-> progress_q < las_pkg::OneQ16)
    else $error("progress reached 1.0 while playing");

  a_idle_at_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !playing_q |-> progress_q == las_pkg::OneQ16)
    else $error("stopped with progress below 1.0");

  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= las_pkg::CntW'(las_pkg::ResultCap))
    else $error("word count past cap");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && word_last) |=> state_q == StIdle)
    else $error("sequencer busy after last word");

  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == StDiv)
    else $error("divider finished outside divide phase");
`endif

endmodule
